[rtl/core/lnlr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnlr_pkg
// Types, constants and helpers shared by the longest letter run block.
// ----------------------------------------------------------------------------
package lnlr_pkg;

  localparam int unsigned SLOTS = 26;
  localparam int unsigned LEN_W = $clog2(SLOTS + 1);
  localparam int unsigned IDX_W = $clog2(SLOTS);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SLOTS-1:0][7:0] run_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       out_empty;
  } out_item_t;

  // Best run handed to the drain stage when a string ends.
  typedef struct packed {
    run_t bytes;
    len_t len;
  } best_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

[rtl/core/lnlr_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnlr_window
// Current run window and best run store, updated once per accepted beat.
// ----------------------------------------------------------------------------
module lnlr_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  lnlr_pkg::in_item_t item_i,
  output lnlr_pkg::best_t    best_o
);
  import lnlr_pkg::*;

  run_t win_q, win_d;
  len_t wlen_q, wlen_d;
  run_t best_q, best_d;
  len_t blen_q, blen_d;

  logic [SLOTS-1:0] hit;
  logic             any_hit;
  idx_t             hit_idx;
  run_t             cut;
  len_t             keep;
  logic [7:0]       key;
  logic [IDX_W:0]   src;

  always_comb begin
    key = fold_case(item_i.in_char);
    for (int k = 0; k < SLOTS; k++) begin
      hit[k] = (len_t'(k) < wlen_q) && (fold_case(win_q[k]) == key);
    end
    any_hit = |hit;
    // Window letters are distinct, so at most one slot matches.
    hit_idx = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (hit[k]) begin
        hit_idx = hit_idx | idx_t'(k);
      end
    end

    for (int k = 0; k < SLOTS; k++) begin
      src = (IDX_W+1)'(k) + (IDX_W+1)'(hit_idx) + (IDX_W+1)'(1);
      if (!any_hit) begin
        cut[k] = win_q[k];
      end else if (src < (IDX_W+1)'(SLOTS)) begin
        cut[k] = win_q[src[IDX_W-1:0]];
      end else begin
        cut[k] = '0;
      end
    end
    keep = any_hit ? (wlen_q - len_t'(hit_idx) - len_t'(1)) : wlen_q;

    win_d  = cut;
    wlen_d = keep;
    if (!is_letter(item_i.in_char)) begin
      win_d  = win_q;
      wlen_d = '0;
    end else if (keep < len_t'(SLOTS)) begin
      win_d[keep[IDX_W-1:0]] = item_i.in_char;
      wlen_d = keep + len_t'(1);
    end

    best_d = best_q;
    blen_d = blen_q;
    if (wlen_d > blen_q) begin
      best_d = win_d;
      blen_d = wlen_d;
    end
  end

  assign best_o.bytes = best_d;
  assign best_o.len   = blen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
      blen_q <= '0;
    end else if (take_i) begin
      if (item_i.in_last) begin
        wlen_q <= '0;
        blen_q <= '0;
      end else begin
        wlen_q <= wlen_d;
        blen_q <= blen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      win_q  <= win_d;
      best_q <= best_d;
    end
  end

endmodule

[rtl/core/lnlr_drain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnlr_drain
// Holds a finished best run and sends it out one character per beat.
// ----------------------------------------------------------------------------
module lnlr_drain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lnlr_pkg::best_t     best_i,
  output logic                busy_o,
  output logic                done_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lnlr_pkg::out_item_t out_data_o
);
  import lnlr_pkg::*;

  run_t buf_q;
  len_t len_q;
  idx_t idx_q;
  logic empty_q;
  logic busy_q;
  logic final_beat;

  assign final_beat  = (len_t'(idx_q) + len_t'(1)) == len_q;
  assign busy_o      = busy_q;
  assign done_o      = busy_q && out_ready_i && final_beat;
  assign out_valid_o = busy_q;

  assign out_data_o.out_char  = empty_q ? 8'h00 : buf_q[idx_q];
  assign out_data_o.out_last  = final_beat;
  assign out_data_o.out_empty = empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (final_beat) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + idx_t'(1);
      end
    end
  end

  // A string without letters still yields one beat, flagged empty.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q   <= best_i.bytes;
      empty_q <= (best_i.len == '0);
      len_q   <= (best_i.len == '0) ? len_t'(1) : best_i.len;
    end
  end

endmodule

[rtl/core/longest_nonrepeating_letter_run.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_nonrepeating_letter_run
// Finds the longest run of distinct letters (case folded) in a byte string
// and sends it out, one character per beat, after the last input byte.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake                | Payload
// in      | in  | in_valid_i / in_ready_o  | in_data_i  (in_char, in_last)
// out     | out | out_valid_o / out_ready_i| out_data_o (out_char, out_last,
//         |     |                          |             out_empty)
//
// One input beat is taken per ready cycle; the window compare and cut complete
// in the cycle of acceptance. A string of N bytes whose best run has L
// letters yields L output beats (one if it has no letters), starting the
// cycle after its last byte. Bytes of the next string flow in while a run
// drains; a last byte waits only while the previous run has beats left.
// Reset clears the run lengths and the drain stage at once.
// ----------------------------------------------------------------------------
module longest_nonrepeating_letter_run (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lnlr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lnlr_pkg::out_item_t out_data_o
);
  import lnlr_pkg::*;

  logic  take;
  logic  busy;
  logic  done;
  best_t best;

  assign in_ready_o = !busy || !in_data_i.in_last || done;
  assign take       = in_valid_i && in_ready_o;

  lnlr_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_data_i),
    .best_o (best)
  );

  lnlr_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && in_data_i.in_last),
    .best_i      (best),
    .busy_o      (busy),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/lnlr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnlr_checker
// Port-level checks on the longest letter run block, bound to the top level.
// ----------------------------------------------------------------------------
module lnlr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input lnlr_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lnlr_pkg::out_item_t out_data_o
);
  import lnlr_pkg::*;

  logic last_take;
  assign last_take = in_valid_i && in_ready_o && in_data_i.in_last;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_empty |->
      out_data_o.out_last && (out_data_o.out_char == 8'h00))
    else $error("empty result is not a single zero beat");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_take |=> out_valid_o)
    else $error("no result after last input beat");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.out_last && !last_take |=> !out_valid_o)
    else $error("results continue past the final beat");

endmodule

bind longest_nonrepeating_letter_run lnlr_checker u_lnlr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[dv/longest_nonrepeating_letter_run_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_nonrepeating_letter_run_tb
// Streams directed and random byte strings into the block and checks every
// output beat, in order, against an in-bench model of the longest run of
// distinct letters. Both channels see random bursts of idle cycles.
// ----------------------------------------------------------------------------
module longest_nonrepeating_letter_run_tb;
  import lnlr_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam int unsigned ITEM_TARGET  = 370;
  localparam int unsigned QUIET_AFTER  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT = 10;

  // Tracks the current and the longest run of one string and holds the
  // characters that the block still owes on its output.
  class longest_run_tracker;
    logic [7:0] run_now [$];
    logic [7:0] run_best [$];
    out_item_t  expected_chars [$];
    int unsigned failures;

    // Setting bit 5 maps both cases of a letter onto the lower case range.
    function logic alpha_byte(logic [7:0] c);
      return ((c | 8'h20) >= CHAR_LOWER_A) && ((c | 8'h20) <= CHAR_LOWER_Z);
    endfunction

    function void note_byte(in_item_t beat);
      int hit;
      out_item_t want;
      hit = -1;
      if (!alpha_byte(beat.in_char)) begin
        run_now.delete();
      end else begin
        foreach (run_now[k]) begin
          if (hit < 0 && (run_now[k] | 8'h20) == (beat.in_char | 8'h20)) begin
            hit = k;
          end
        end
        // Drop everything up to and including the earlier copy.
        repeat (hit + 1) void'(run_now.pop_front());
        if (run_now.size() < SLOTS) begin
          run_now.push_back(beat.in_char);
        end
        if (run_now.size() > run_best.size()) begin
          run_best = run_now;
        end
      end
      if (beat.in_last) begin
        if (run_best.size() == 0) begin
          want.out_char  = 8'h00;
          want.out_last  = 1'b1;
          want.out_empty = 1'b1;
          expected_chars.push_back(want);
        end else begin
          foreach (run_best[k]) begin
            want.out_char  = run_best[k];
            want.out_last  = (k == run_best.size() - 1);
            want.out_empty = 1'b0;
            expected_chars.push_back(want);
          end
        end
        run_now.delete();
        run_best.delete();
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (expected_chars.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: unexpected beat: char %h last %b empty %b",
                   $time, got.out_char, got.out_last, got.out_empty);
        end
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char || got.out_last !== want.out_last ||
          got.out_empty !== want.out_empty) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: beat mismatch: expected char %h last %b empty %b, got char %h last %b empty %b",
                   $time, want.out_char, want.out_last, want.out_empty,
                   got.out_char, got.out_last, got.out_empty);
        end
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  longest_run_tracker tracker = new;
  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;
  bit          quiet      = 1'b0;

  longest_nonrepeating_letter_run DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(logic [7:0] c, logic last);
    in_item_t beat;
    beat.in_char = c;
    beat.in_last = last;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_byte(beat);
    bytes_sent++;
    quiet = (bytes_sent >= QUIET_AFTER);
  endtask

  task automatic send_string(byte_q_t text);
    foreach (text[k]) begin
      send_byte(text[k], k == text.size() - 1);
    end
  endtask

  function automatic logic [7:0] any_case(logic [7:0] lower);
    return ($urandom_range(0, 1) != 0) ? lower - CASE_OFFSET : lower;
  endfunction

  function automatic logic [7:0] non_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (tracker.alpha_byte(c));
    return c;
  endfunction

  task automatic send_random_string();
    byte_q_t     text;
    logic [7:0]  letters [26];
    logic [7:0]  swap;
    int unsigned mode;
    int unsigned len;
    int unsigned span;
    int unsigned j;
    mode = $urandom_range(0, 19);
    for (int k = 0; k < 26; k++) begin
      letters[k] = CHAR_LOWER_A + 8'(k);
    end
    for (int k = 25; k > 0; k--) begin
      j = $urandom_range(0, k);
      swap = letters[k];
      letters[k] = letters[j];
      letters[j] = swap;
    end
    if (mode < 8) begin
      // Letters drawn from a random set of 2 to 26, so repeats and window cuts occur.
      span = $urandom_range(2, 26);
      len  = $urandom_range(1, 30);
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) begin
          text.push_back(non_letter());
        end else begin
          text.push_back(any_case(letters[$urandom_range(0, span - 1)]));
        end
      end
    end else if (mode < 14) begin
      // Distinct letters after a short random lead-in; now and then the
      // whole alphabet, which makes the longest possible run.
      repeat ($urandom_range(0, 3)) text.push_back(any_case(letters[$urandom_range(0, 25)]));
      len = (mode >= 12) ? 26 : $urandom_range(1, 26);
      for (int k = 0; k < len; k++) begin
        text.push_back(any_case(letters[k]));
      end
    end else if (mode < 17) begin
      len = $urandom_range(1, 12);
      repeat (len) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(30, 60);
      repeat (len) begin
        if ($urandom_range(0, 14) == 0) begin
          text.push_back(non_letter());
        end else begin
          text.push_back(any_case(letters[$urandom_range(0, 25)]));
        end
      end
    end
    send_string(text);
  endtask

  // Output side: check each accepted beat, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_beat(out_data_o);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && rst_ni && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    byte_q_t text;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A lone null byte: no letters at all.
    text = {8'h00};
    send_string(text);
    // Neighbors of both letter ranges and high bytes are all non-letters.
    text = {8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'hFF};
    send_string(text);
    // "AzaZ": repeats that differ only in case.
    text = {8'h41, 8'h7A, 8'h61, 8'h5A};
    send_string(text);
    // "ab1cd": a digit splits two runs of equal length; the first one wins.
    text = {8'h61, 8'h62, 8'h31, 8'h63, 8'h64};
    send_string(text);
    // "abcabcbb": repeated letters cut the window back.
    text = {8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62};
    send_string(text);
    // "Z": a single letter that is also the last byte.
    text = {8'h5A};
    send_string(text);

    while (bytes_sent < ITEM_TARGET) begin
      send_random_string();
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
